>>> src/bepc_pkg.sv
package bepc_pkg;

  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CNT_W        = 22;
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [CNT_W-1:0]     CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

  typedef struct packed {
    logic right_en;
    logic right_even;
    logic lower_en;
    logic lower_even;
    logic left;
    logic px;
    logic last;
  } pair_t;

endpackage

>>> src/bepc_line_mem.sv
module bepc_line_mem #(
  parameter int MAX_COLS = bepc_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [$clog2(MAX_COLS)-1:0] addr,
  input  logic                        wr_data,
  output logic                        rd_data
);

  logic mem [MAX_COLS];

  // read-first: the row above is seen before this pixel overwrites it
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data   <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

endmodule

>>> src/bepc_scan.sv
module bepc_scan #(
  parameter int MAX_COLS = bepc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bepc_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        hold,
  input  logic                        pixel,
  input  logic [bepc_pkg::CFG_W-1:0]  frame_rows,
  input  logic [bepc_pkg::CFG_W-1:0]  frame_cols,
  output logic [$clog2(MAX_COLS)-1:0] col,
  output logic                        s1_valid,
  output bepc_pkg::pair_t             s1
);
  import bepc_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int ECW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int ERW = (CFG_W > RW + 1) ? CFG_W : RW + 1;

  logic [ECW-1:0] cols_ext;
  logic [ERW-1:0] rows_ext;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row;
  logic [RW-1:0]  row;
  logic           left;
  pair_t          cur;

  // clamp sizes into [2, max]
  always_comb begin
    cols_ext = ECW'(frame_cols);
    rows_ext = ERW'(frame_rows);
    if (cols_ext < ECW'(2)) begin
      last_col = CW'(1);
    end else if (cols_ext > ECW'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(cols_ext - ECW'(1));
    end
    if (rows_ext < ERW'(2)) begin
      last_row = RW'(1);
    end else if (rows_ext > ERW'(MAX_ROWS)) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(rows_ext - ERW'(1));
    end
  end

  always_comb begin
    cur.right_en   = (col != '0) && (row < last_row) && (col <= last_col);
    cur.right_even = col[0];
    cur.lower_en   = (row != '0) && (row <= last_row) && (col < last_col);
    cur.lower_even = row[0];
    cur.left       = left;
    cur.px         = pixel;
    cur.last       = (col >= last_col) && (row >= last_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      left     <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept | hold;
      if (accept) begin
        left <= cur.last ? 1'b0 : pixel;
        if (col >= last_col) begin
          col <= '0;
          row <= (row >= last_row) ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= cur;
    end
  end

endmodule

>>> src/bepc_score.sv
module bepc_score (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  bepc_pkg::pair_t            s1,
  input  logic                       above,
  output logic                       hold,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bepc_pkg::CNT_W-1:0] wrong_edges,
  output logic [bepc_pkg::CNT_W-1:0] correct_edges,
  output logic                       has_wrong
);
  import bepc_pkg::*;

  logic [CNT_W-1:0] wrong_total;
  logic [CNT_W-1:0] correct_total;
  logic [CNT_W-1:0] wrong_next;
  logic [CNT_W-1:0] correct_next;
  logic [CNT_W:0]   wrong_sum;
  logic [CNT_W:0]   correct_sum;
  logic [1:0]       wrong_inc;
  logic [1:0]       correct_inc;
  logic             r_diff;
  logic             l_diff;
  logic             fire;

  assign hold = s1_valid && s1.last && out_valid && out_stall;
  assign fire = s1_valid && !hold;

  always_comb begin
    r_diff      = s1.right_en && (s1.left != s1.px);
    l_diff      = s1.lower_en && (above != s1.px);
    correct_inc = 2'(r_diff && (s1.left == s1.right_even))
                + 2'(l_diff && (above == s1.lower_even));
    wrong_inc   = 2'(r_diff && (s1.left != s1.right_even))
                + 2'(l_diff && (above != s1.lower_even));
    wrong_sum   = {1'b0, wrong_total} + (CNT_W + 1)'(wrong_inc);
    correct_sum = {1'b0, correct_total} + (CNT_W + 1)'(correct_inc);
    // saturate
    wrong_next   = (wrong_sum > {1'b0, CNT_MAX}) ? CNT_MAX : wrong_sum[CNT_W-1:0];
    correct_next = (correct_sum > {1'b0, CNT_MAX}) ? CNT_MAX : correct_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrong_total   <= '0;
      correct_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        if (s1.last) begin
          wrong_total   <= '0;
          correct_total <= '0;
        end else begin
          wrong_total   <= wrong_next;
          correct_total <= correct_next;
        end
      end
      if (fire && s1.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1.last) begin
      wrong_edges   <= wrong_next;
      correct_edges <= correct_next;
      has_wrong     <= (wrong_next != '0);
    end
  end

endmodule

>>> src/bitmap_edge_polarity_counter_unit.sv
// bitmap edge polarity counter
//
// pixels enter one per transfer on in_valid/in_stall in row-major order for a
// frame of frame_rows by frame_cols (each clamped to 2..max). register index 0
// sets rows, index 1 sets columns; cfg_ready is always high, and the user must
// make writes between frames or between pixels; the block does not enforce it.
//
// one pixel is taken every cycle while in_stall is low. each pixel reads the
// line buffer entry of its column when it is taken and is scored from the s1
// register and the registered line buffer output; a frame's result is then
// registered and leaves on out_valid/out_stall. the line buffer read and write
// share one port per pixel, which sets the one-pixel-per-cycle figure.
//
// the result waits in an output register while out_stall is high; further
// pixels keep flowing, and in_stall rises only when the next frame's result
// is ready and the output register still holds the previous one.
//
// reset clears position, counters and the output valid flag and sets both
// sizes to 2. the line buffer needs no clearing.
module bitmap_edge_polarity_counter_unit #(
  parameter int MAX_COLS = bepc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bepc_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bepc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bepc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bepc_pkg::CNT_W-1:0]     wrong_edges,
  output logic [bepc_pkg::CNT_W-1:0]     correct_edges,
  output logic                           has_wrong
);
  import bepc_pkg::*;

  logic [CFG_W-1:0]            frame_rows;
  logic [CFG_W-1:0]            frame_cols;
  logic [$clog2(MAX_COLS)-1:0] col;
  logic                        accept;
  logic                        hold;
  logic                        s1_valid;
  pair_t                       s1;
  logic                        above;

  assign cfg_ready = 1'b1;
  assign in_stall  = hold;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= CFG_W'(2);
      frame_cols <= CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        REG_FRAME_COLS: frame_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  bepc_scan #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .hold       (hold),
    .pixel      (pixel),
    .frame_rows (frame_rows),
    .frame_cols (frame_cols),
    .col        (col),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  bepc_line_mem #(
    .MAX_COLS(MAX_COLS)
  ) u_line_mem (
    .clk     (clk),
    .en      (accept),
    .addr    (col),
    .wr_data (pixel),
    .rd_data (above)
  );

  bepc_score u_score (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .above         (above),
    .hold          (hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .wrong_edges   (wrong_edges),
    .correct_edges (correct_edges),
    .has_wrong     (has_wrong)
  );

  // input backs up only behind a full, stalled output register
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid && s1.last))
    else $error("input stalled without a pending result");

  a_flag_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_wrong == (wrong_edges != '0)))
    else $error("has_wrong disagrees with wrong_edges");

  a_reset_empties_out: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output not empty after reset");

endmodule
